@@ rtl/broadcast_offset_generator_macros.svh @@
// Assertion macros for the broadcast offset generator module.
`ifndef BROADCAST_OFFSET_GENERATOR_MACROS_SVH
`define BROADCAST_OFFSET_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS
`define BOG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("broadcast offset generator check failed");
`define BOG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("broadcast offset generator check failed");
`else
`define BOG_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BOG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/bog_pkg.sv @@
package bog_pkg;

    localparam int LEN_W       = 48;
    localparam int MODE_W      = 2;
    localparam int CNT_W       = 3;
    localparam int RED_W       = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;

    localparam int DEF_MAX_AXES  = 4;
    localparam int DEF_AXIS_BITS = 12;

    localparam logic [MODE_W-1:0] OP_COPY_LEFT  = 2'd0;
    localparam logic [MODE_W-1:0] OP_COPY_RIGHT = 2'd1;
    localparam logic [MODE_W-1:0] OP_DOT        = 2'd2;
    localparam logic [MODE_W-1:0] OP_ELEMWISE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_OP_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_AXES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_AXES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_SHAPE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SHAPE = 3'd4;

    localparam logic [MODE_W-1:0] RST_OP_MODE = OP_ELEMWISE;
    localparam logic [CNT_W-1:0]  RST_AXES    = 3'd1;

    typedef struct packed {
        logic restart;
    } in_item_t;

    typedef struct packed {
        logic [LEN_W-1:0] left_offset;
        logic [LEN_W-1:0] right_offset;
        logic             last;
        logic             broadcast_used;
        logic [LEN_W-1:0] output_length;
        logic [LEN_W-1:0] left_length;
        logic [LEN_W-1:0] right_length;
        logic [RED_W-1:0] reduce_length;
    } out_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } cfg_item_t;

endpackage

@@ rtl/bog_chan_if.sv @@
interface bog_chan_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

@@ rtl/broadcast_offset_generator.sv @@
// Broadcast offset generator. Each item accepted on req yields one item on rsp with the next
// pair of left and right element offsets in output order, innermost axis fastest, plus the
// broadcast flag and the derived lengths. The result is registered and is offered on rsp in
// the cycle after its item is accepted. One item is taken per clock cycle while rsp keeps up and
// the sequencer is idle; while a result waits, the next item can enter only in the cycle that the
// waiting result is taken. Each write to a defined configuration register (and reset) starts a
// multiply sequencer that walks the axes one per cycle to rebuild the strides and lengths, so
// req.ready stays low until every axis is walked. Configuration writes are taken in every cycle.
`include "broadcast_offset_generator_macros.svh"

module broadcast_offset_generator #(
    parameter int MAX_AXES  = bog_pkg::DEF_MAX_AXES,
    parameter int AXIS_BITS = bog_pkg::DEF_AXIS_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    bog_chan_if.sink   req,
    bog_chan_if.source rsp,
    bog_chan_if.sink   cfg
);

    localparam int SHAPE_W    = MAX_AXES * AXIS_BITS;
    localparam int AXIS_IDX_W = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
    localparam int LEN_W      = bog_pkg::LEN_W;
    localparam int CNT_W      = bog_pkg::CNT_W;
    localparam logic [CNT_W:0] MAX_CNT = (CNT_W + 1)'(MAX_AXES);
    localparam logic [AXIS_IDX_W-1:0] LAST_IDX = AXIS_IDX_W'(MAX_AXES - 1);

    logic [bog_pkg::MODE_W-1:0] op_mode_reg;
    logic [CNT_W-1:0]           left_axes_reg;
    logic [CNT_W-1:0]           right_axes_reg;
    logic [SHAPE_W-1:0]         left_shape_reg;
    logic [SHAPE_W-1:0]         right_shape_reg;

    logic                  settle_busy_reg;
    logic [AXIS_IDX_W-1:0] settle_idx_reg;
    logic [LEN_W-1:0]      llen_acc_reg;
    logic [LEN_W-1:0]      rlen_acc_reg;
    logic [LEN_W-1:0]      olen_acc_reg;
    logic [LEN_W-1:0]      sl_acc_reg;
    logic [LEN_W-1:0]      sr_acc_reg;
    logic [LEN_W-1:0]      stride_l_reg [MAX_AXES];
    logic [LEN_W-1:0]      stride_r_reg [MAX_AXES];

    logic [AXIS_BITS-1:0] digit_reg  [MAX_AXES];
    logic [LEN_W-1:0]     term_l_reg [MAX_AXES];
    logic [LEN_W-1:0]     term_r_reg [MAX_AXES];
    logic [AXIS_BITS-1:0] digit_next  [MAX_AXES];
    logic [LEN_W-1:0]     term_l_next [MAX_AXES];
    logic [LEN_W-1:0]     term_r_next [MAX_AXES];

    bog_pkg::out_item_t out_reg;
    bog_pkg::out_item_t out_next;
    logic               out_valid_reg;

    logic [AXIS_BITS-1:0] dl [MAX_AXES];
    logic [AXIS_BITS-1:0] dr [MAX_AXES];
    logic [AXIS_BITS-1:0] dm [MAX_AXES];
    logic [MAX_AXES-1:0]  in_rng;
    logic [MAX_AXES-1:0]  shape_diff;
    logic [CNT_W:0]       la;
    logic [CNT_W:0]       ra;
    logic [CNT_W:0]       mx;
    logic                 start_one;
    logic                 bcast;
    logic                 cfg_hit;
    logic                 accept_in;
    logic                 step_active;
    logic [AXIS_BITS-1:0] dl_sel;
    logic [AXIS_BITS-1:0] dr_sel;
    logic [AXIS_BITS-1:0] dm_sel;

    assign cfg.ready   = 1'b1;
    assign req.ready   = !settle_busy_reg && (!out_valid_reg || rsp.ready);
    assign accept_in   = req.valid && req.ready;
    assign rsp.valid   = out_valid_reg;
    assign rsp.data    = out_reg;

    always_comb
    begin
        cfg_hit = 1'b0;
        case (cfg.data.index)
            bog_pkg::REG_OP_MODE, bog_pkg::REG_LEFT_AXES, bog_pkg::REG_RIGHT_AXES,
            bog_pkg::REG_LEFT_SHAPE, bog_pkg::REG_RIGHT_SHAPE:
                cfg_hit = cfg.valid;
            default:
                cfg_hit = 1'b0;
        endcase
    end

    // Axis sizes after count clamping; a zero size and an axis beyond the count both read as 1.
    always_comb
    begin
        logic [AXIS_BITS-1:0] lf;
        logic [AXIS_BITS-1:0] rf;
        la = ({1'b0, left_axes_reg} > MAX_CNT) ? MAX_CNT : {1'b0, left_axes_reg};
        ra = ({1'b0, right_axes_reg} > MAX_CNT) ? MAX_CNT : {1'b0, right_axes_reg};
        mx = (la > ra) ? la : ra;
        start_one = (op_mode_reg == bog_pkg::OP_DOT);
        for (int j = 0; j < MAX_AXES; j++)
        begin
            lf = left_shape_reg[j*AXIS_BITS +: AXIS_BITS];
            rf = right_shape_reg[j*AXIS_BITS +: AXIS_BITS];
            dl[j] = ((CNT_W + 1)'(j) < la && lf != '0) ? lf : AXIS_BITS'(1);
            dr[j] = ((CNT_W + 1)'(j) < ra && rf != '0) ? rf : AXIS_BITS'(1);
            dm[j] = (dl[j] > dr[j]) ? dl[j] : dr[j];
            in_rng[j] = (j != 0 || !start_one) && ((CNT_W + 1)'(j) < mx);
            shape_diff[j] = (dl[j] != dr[j]);
        end
        bcast = (op_mode_reg == bog_pkg::OP_DOT || op_mode_reg == bog_pkg::OP_ELEMWISE)
            && (la != ra || shape_diff != '0);
    end

    assign dl_sel      = dl[settle_idx_reg];
    assign dr_sel      = dr[settle_idx_reg];
    assign dm_sel      = dm[settle_idx_reg];
    assign step_active = (settle_idx_reg != '0) || !start_one;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_mode_reg     <= bog_pkg::RST_OP_MODE;
            left_axes_reg   <= bog_pkg::RST_AXES;
            right_axes_reg  <= bog_pkg::RST_AXES;
            left_shape_reg  <= {MAX_AXES{AXIS_BITS'(1)}};
            right_shape_reg <= {MAX_AXES{AXIS_BITS'(1)}};
        end
        else if (cfg_hit)
        begin
            case (cfg.data.index)
                bog_pkg::REG_OP_MODE:
                    op_mode_reg <= cfg.data.value[bog_pkg::MODE_W-1:0];
                bog_pkg::REG_LEFT_AXES:
                    left_axes_reg <= cfg.data.value[CNT_W-1:0];
                bog_pkg::REG_RIGHT_AXES:
                    right_axes_reg <= cfg.data.value[CNT_W-1:0];
                bog_pkg::REG_LEFT_SHAPE:
                    left_shape_reg <= SHAPE_W'(cfg.data.value);
                bog_pkg::REG_RIGHT_SHAPE:
                    right_shape_reg <= SHAPE_W'(cfg.data.value);
                default:
                    op_mode_reg <= op_mode_reg;
            endcase
        end
    end

    // Stride and length sequencer: one axis per cycle, one multiply per accumulator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_busy_reg <= 1'b1;
            settle_idx_reg  <= '0;
            llen_acc_reg    <= LEN_W'(1);
            rlen_acc_reg    <= LEN_W'(1);
            olen_acc_reg    <= LEN_W'(1);
            sl_acc_reg      <= LEN_W'(1);
            sr_acc_reg      <= LEN_W'(1);
        end
        else if (cfg_hit)
        begin
            settle_busy_reg <= 1'b1;
            settle_idx_reg  <= '0;
            llen_acc_reg    <= LEN_W'(1);
            rlen_acc_reg    <= LEN_W'(1);
            olen_acc_reg    <= LEN_W'(1);
            sl_acc_reg      <= LEN_W'(1);
            sr_acc_reg      <= LEN_W'(1);
        end
        else if (settle_busy_reg)
        begin
            llen_acc_reg <= LEN_W'(llen_acc_reg * dl_sel);
            rlen_acc_reg <= LEN_W'(rlen_acc_reg * dr_sel);
            if (step_active)
            begin
                olen_acc_reg <= LEN_W'(olen_acc_reg * dm_sel);
                sl_acc_reg   <= LEN_W'(sl_acc_reg * dl_sel);
                sr_acc_reg   <= LEN_W'(sr_acc_reg * dr_sel);
            end
            if (settle_idx_reg == LAST_IDX)
            begin
                settle_busy_reg <= 1'b0;
            end
            else
            begin
                settle_idx_reg <= settle_idx_reg + AXIS_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (settle_busy_reg && !cfg_hit)
        begin
            stride_l_reg[settle_idx_reg] <= sl_acc_reg;
            stride_r_reg[settle_idx_reg] <= sr_acc_reg;
        end
    end

    // Offset step: odometer over the output digits, with running per-axis stride sums.
    always_comb
    begin
        logic [AXIS_BITS-1:0] d_eff;
        logic [LEN_W-1:0]     tl_eff;
        logic [LEN_W-1:0]     tr_eff;
        logic                 carry;
        logic                 last;
        logic [LEN_W-1:0]     lo;
        logic [LEN_W-1:0]     ro;
        logic [MAX_AXES-1:0]  at_max;
        carry = 1'b1;
        last  = 1'b1;
        lo    = '0;
        ro    = '0;
        for (int j = 0; j < MAX_AXES; j++)
        begin
            d_eff  = req.data.restart ? '0 : digit_reg[j];
            tl_eff = req.data.restart ? '0 : term_l_reg[j];
            tr_eff = req.data.restart ? '0 : term_r_reg[j];
            at_max[j] = ({1'b0, d_eff} + (AXIS_BITS + 1)'(1)) >= {1'b0, dm[j]};
            digit_next[j]  = d_eff;
            term_l_next[j] = tl_eff;
            term_r_next[j] = tr_eff;
            if (in_rng[j])
            begin
                if (d_eff < dl[j])
                begin
                    lo = lo + tl_eff;
                end
                if (d_eff < dr[j])
                begin
                    ro = ro + tr_eff;
                end
                last = last && at_max[j];
                if (carry)
                begin
                    if (!at_max[j])
                    begin
                        digit_next[j]  = d_eff + AXIS_BITS'(1);
                        term_l_next[j] = tl_eff + stride_l_reg[j];
                        term_r_next[j] = tr_eff + stride_r_reg[j];
                        carry = 1'b0;
                    end
                    else
                    begin
                        digit_next[j]  = '0;
                        term_l_next[j] = '0;
                        term_r_next[j] = '0;
                    end
                end
            end
            else
            begin
                digit_next[j]  = '0;
                term_l_next[j] = '0;
                term_r_next[j] = '0;
            end
        end
        if (!bcast)
        begin
            last = 1'b1;
            lo   = '0;
            ro   = '0;
        end
        if (last)
        begin
            for (int j = 0; j < MAX_AXES; j++)
            begin
                digit_next[j]  = '0;
                term_l_next[j] = '0;
                term_r_next[j] = '0;
            end
        end
        out_next.left_offset    = lo;
        out_next.right_offset   = ro;
        out_next.last           = last;
        out_next.broadcast_used = bcast;
        out_next.left_length    = llen_acc_reg;
        out_next.right_length   = rlen_acc_reg;
        out_next.reduce_length  = start_one ? bog_pkg::RED_W'(dl[0]) : bog_pkg::RED_W'(1);
        case (op_mode_reg)
            bog_pkg::OP_COPY_LEFT:  out_next.output_length = llen_acc_reg;
            bog_pkg::OP_COPY_RIGHT: out_next.output_length = rlen_acc_reg;
            default:                out_next.output_length = olen_acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_AXES; j++)
            begin
                digit_reg[j]  <= '0;
                term_l_reg[j] <= '0;
                term_r_reg[j] <= '0;
            end
        end
        else if (cfg_hit)
        begin
            for (int j = 0; j < MAX_AXES; j++)
            begin
                digit_reg[j]  <= '0;
                term_l_reg[j] <= '0;
                term_r_reg[j] <= '0;
            end
        end
        else if (accept_in)
        begin
            for (int j = 0; j < MAX_AXES; j++)
            begin
                digit_reg[j]  <= digit_next[j];
                term_l_reg[j] <= term_l_next[j];
                term_r_reg[j] <= term_r_next[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept_in)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            out_reg <= out_next;
        end
    end

    `BOG_ASSERT_SAME(a_plain_single, clk, rst_n,
        rsp.valid && !rsp.data.broadcast_used,
        rsp.data.last && rsp.data.left_offset == '0 && rsp.data.right_offset == '0)
    `BOG_ASSERT_NEXT(a_cfg_settles, clk, rst_n, cfg_hit, settle_busy_reg && !req.ready)
    `BOG_ASSERT_NEXT(a_restart_zero, clk, rst_n, accept_in && req.data.restart,
        rsp.valid && rsp.data.left_offset == '0 && rsp.data.right_offset == '0)

endmodule
